// ===== src/scqap_pkg.sv =====
package scqap_pkg;

    // Widths of the fixed fields and of the internal Q30 datapath.
    localparam int ANGLE_W  = 32;
    localparam int RESULT_W = 32;
    localparam int Q_W      = 32;
    localparam int QF       = 30;

    // Default number formats.
    localparam int ANGLE_FRAC_BITS_DEF  = 28;
    localparam int RESULT_FRAC_BITS_DEF = 30;

    // pi in Q29, and one in Q30.
    localparam logic signed [Q_W-1:0] PI_Q29 = 32'sd1686629713;
    localparam logic signed [Q_W-1:0] ONE_Q  = 32'sd1073741824;

    // Minimax coefficients for the quarter angle, rounded to Q30.
    localparam logic signed [Q_W-1:0] COEF_S1 = 32'sd209544;
    localparam logic signed [Q_W-1:0] COEF_S2 = 32'sd8946590;
    localparam logic signed [Q_W-1:0] COEF_S3 = 32'sd178956841;
    localparam logic signed [Q_W-1:0] COEF_C1 = 32'sd26235;
    localparam logic signed [Q_W-1:0] COEF_C2 = 32'sd1491139;
    localparam logic signed [Q_W-1:0] COEF_C3 = 32'sd44739220;

endpackage

// ===== src/scqap_qmul.sv =====
// Two-stage Q30 multiplier: y = round(a * b) + c, rounding to nearest with ties
// away from zero on the magnitude. The first stage forms the magnitude product,
// the second rounds, restores the sign and adds c.
module scqap_qmul (
    input  logic                                 aclk,
    input  logic                                 en,
    input  logic signed [scqap_pkg::Q_W-1:0]     a,
    input  logic signed [scqap_pkg::Q_W-1:0]     b,
    input  logic signed [scqap_pkg::Q_W-1:0]     c,
    output logic signed [scqap_pkg::Q_W-1:0]     y
);

    localparam int W  = scqap_pkg::Q_W;
    localparam int QF = scqap_pkg::QF;
    localparam int PW = 2 * W;
    localparam int MW = PW - QF;

    logic [W-1:0]            a_mag;
    logic [W-1:0]            b_mag;
    logic [PW-1:0]           prod_next;
    logic [PW-1:0]           prod_reg;
    logic                    neg_reg;
    logic signed [W-1:0]     c_reg;
    logic [PW-1:0]           prod_rnd;
    logic [MW-1:0]           mag;
    logic signed [MW:0]      res;

    assign a_mag     = a[W-1] ? (~a + W'(1)) : a;
    assign b_mag     = b[W-1] ? (~b + W'(1)) : b;
    assign prod_next = PW'(a_mag) * PW'(b_mag);

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg <= prod_next;
            neg_reg  <= a[W-1] ^ b[W-1];
            c_reg    <= c;
        end
    end

    assign prod_rnd = prod_reg + (PW'(1) << (QF - 1));
    assign mag      = prod_rnd[PW-1:QF];
    assign res      = neg_reg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});

    always_ff @(posedge aclk) begin
        if (en) begin
            y <= W'(res + (MW+1)'(c_reg));
        end
    end

endmodule

// ===== src/sincos_quarter_angle_poly_core.sv =====
// Channel   Direction  Ports                          Contents
// s_        in         s_valid s_ready s_angle        angle, signed Q(32-F).F radians
// m_        out        m_valid m_ready m_sine m_cosine sine and cosine, signed Q(32-R).R
//
// One transaction is accepted in every cycle in which the result register does not
// hold one that is not taken. Each result passes through eighteen register
// stages, made of the clamp, the quartering, the chain of seven two-stage Q30
// multipliers, one subtraction stage and the result register.
// Reset (aresetn, synchronous, active low) clears only the valid bits.
// The whole pipeline advances together; when the result register holds a
// transaction that is not taken, every stage holds, so nothing is lost or repeated.
module sincos_quarter_angle_poly_core #(
    parameter int ANGLE_FRAC_BITS  = scqap_pkg::ANGLE_FRAC_BITS_DEF,
    parameter int RESULT_FRAC_BITS = scqap_pkg::RESULT_FRAC_BITS_DEF
) (
    input  logic                                     aclk,
    input  logic                                     aresetn,
    input  logic                                     s_valid,
    output logic                                     s_ready,
    input  logic signed [scqap_pkg::ANGLE_W-1:0]     s_angle,
    output logic                                     m_valid,
    input  logic                                     m_ready,
    output logic signed [scqap_pkg::RESULT_W-1:0]    m_sine,
    output logic signed [scqap_pkg::RESULT_W-1:0]    m_cosine
);

    localparam int W     = scqap_pkg::Q_W;
    localparam int QF    = scqap_pkg::QF;
    localparam int LAT   = 18;
    localparam int X_SH  = QF - ANGLE_FRAC_BITS;
    localparam int XW    = 34;
    localparam int OW    = 36;
    localparam int RES_SH = QF - RESULT_FRAC_BITS;
    localparam logic signed [W-1:0] PI_IN =
        W'(scqap_pkg::PI_Q29 >>> (29 - ANGLE_FRAC_BITS));
    localparam logic [OW-1:0] RND_HALF =
        (RES_SH == 0) ? '0 : (OW'(1) << ((RES_SH > 0) ? (RES_SH - 1) : 0));

    // Rounds a Q30 value to the result format, ties away from zero, and
    // saturates it to the 32-bit result range.
    function automatic logic signed [scqap_pkg::RESULT_W-1:0] to_result(
        input logic signed [OW-1:0] v
    );
        logic [OW-1:0]       mag;
        logic [OW-1:0]       rmag;
        logic signed [OW:0]  r;
        mag  = v[OW-1] ? (~v + OW'(1)) : v;
        rmag = (mag + RND_HALF) >> RES_SH;
        r    = v[OW-1] ? -$signed({1'b0, rmag}) : $signed({1'b0, rmag});
        if (r > $signed((OW+1)'(32'h7FFF_FFFF))) begin
            return 32'sh7FFF_FFFF;
        end else if (r < -$signed((OW+1)'(33'h0_8000_0000))) begin
            return 32'sh8000_0000;
        end else begin
            return W'(r);
        end
    endfunction

    logic                 en;
    logic [LAT-1:0]       vld_reg;

    // The whole pipeline moves whenever the result register is empty or is
    // being emptied in this cycle.
    assign en      = ~m_valid | m_ready;
    assign s_ready = en;
    assign m_valid = vld_reg[LAT-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[LAT-2:0], s_valid};
        end
    end

    // Stage 0: clamp the angle to plus or minus pi.
    logic signed [W-1:0] a_next;
    logic signed [W-1:0] a_reg;

    always_comb begin
        if (s_angle > PI_IN) begin
            a_next = PI_IN;
        end else if (s_angle < -PI_IN) begin
            a_next = -PI_IN;
        end else begin
            a_next = s_angle;
        end
    end

    // Stage 1: bring the angle to Q30 and quarter it with rounding.
    logic signed [XW-1:0] x;
    logic [XW-1:0]        x_mag;
    logic [XW-1:0]        q_mag;
    logic signed [W-1:0]  q_next;
    logic signed [W-1:0]  q_reg;

    assign x      = XW'(a_reg) <<< X_SH;
    assign x_mag  = x[XW-1] ? (~x + XW'(1)) : x;
    assign q_mag  = (x_mag + XW'(2)) >> 2;
    assign q_next = x[XW-1] ? -$signed(W'(q_mag)) : $signed(W'(q_mag));

    always_ff @(posedge aclk) begin
        if (en) begin
            a_reg <= a_next;
            q_reg <= q_next;
        end
    end

    // z = q squared.
    logic signed [W-1:0] z_w;

    scqap_qmul u_mul_z (
        .aclk (aclk), .en (en), .a (q_reg), .b (q_reg), .c ('0), .y (z_w)
    );

    // Delay lines that keep z and q in step with the polynomial chains.
    logic signed [W-1:0] z_dly_reg [0:5];
    logic signed [W-1:0] q_dly_reg [0:7];

    always_ff @(posedge aclk) begin
        if (en) begin
            z_dly_reg[0] <= z_w;
            for (int i = 1; i < 6; i++) begin
                z_dly_reg[i] <= z_dly_reg[i-1];
            end
            q_dly_reg[0] <= q_reg;
            for (int i = 1; i < 8; i++) begin
                q_dly_reg[i] <= q_dly_reg[i-1];
            end
        end
    end

    // Horner steps for sin and cos of the quarter angle, side by side.
    logic signed [W-1:0] u_w;
    logic signed [W-1:0] t_w;
    logic signed [W-1:0] ps_w;
    logic signed [W-1:0] pc_w;
    logic signed [W-1:0] v_w;
    logic signed [W-1:0] c1_w;
    logic signed [W-1:0] sq_w;
    logic signed [W-1:0] cq_w;
    logic signed [W-1:0] hc;

    scqap_qmul u_mul_s1 (
        .aclk (aclk), .en (en), .a (-scqap_pkg::COEF_S1), .b (z_w),
        .c (scqap_pkg::COEF_S2), .y (u_w)
    );
    scqap_qmul u_mul_c1 (
        .aclk (aclk), .en (en), .a (scqap_pkg::COEF_C1), .b (z_w),
        .c (-scqap_pkg::COEF_C2), .y (t_w)
    );
    scqap_qmul u_mul_s2 (
        .aclk (aclk), .en (en), .a (u_w), .b (z_dly_reg[1]),
        .c (-scqap_pkg::COEF_S3), .y (ps_w)
    );
    scqap_qmul u_mul_c2 (
        .aclk (aclk), .en (en), .a (t_w), .b (z_dly_reg[1]),
        .c (scqap_pkg::COEF_C3), .y (pc_w)
    );
    scqap_qmul u_mul_s3 (
        .aclk (aclk), .en (en), .a (ps_w), .b (z_dly_reg[3]), .c ('0), .y (v_w)
    );
    scqap_qmul u_mul_c3 (
        .aclk (aclk), .en (en), .a (pc_w), .b (z_dly_reg[3]), .c ('0), .y (c1_w)
    );

    // The cosine's 1 - z/2 term; z/2 rounded is (z + 1) / 2 since z is never
    // negative.
    assign hc = scqap_pkg::ONE_Q - ((z_dly_reg[5] + W'(1)) >>> 1);

    scqap_qmul u_mul_s4 (
        .aclk (aclk), .en (en), .a (v_w), .b (q_dly_reg[7]),
        .c (q_dly_reg[7]), .y (sq_w)
    );
    scqap_qmul u_mul_c4 (
        .aclk (aclk), .en (en), .a (c1_w), .b (z_dly_reg[5]), .c (hc), .y (cq_w)
    );

    // Quadruple-angle rebuild: sin = 4*cq*sq*(1 - 2*sq^2),
    // cos = 1 + 8*sq^2*(sq^2 - 1).
    logic signed [W-1:0] ss_w;
    logic signed [W-1:0] m1_w;
    logic signed [W-1:0] r_reg;
    logic signed [W-1:0] sm_reg;
    logic signed [W-1:0] ss_reg;
    logic signed [W-1:0] m1_reg;

    scqap_qmul u_mul_ss (
        .aclk (aclk), .en (en), .a (sq_w), .b (sq_w), .c ('0), .y (ss_w)
    );
    scqap_qmul u_mul_cs (
        .aclk (aclk), .en (en), .a (cq_w), .b (sq_w), .c ('0), .y (m1_w)
    );

    always_ff @(posedge aclk) begin
        if (en) begin
            r_reg  <= scqap_pkg::ONE_Q - (ss_w <<< 1);
            sm_reg <= ss_w - scqap_pkg::ONE_Q;
            ss_reg <= ss_w;
            m1_reg <= m1_w;
        end
    end

    logic signed [W-1:0]  pn_w;
    logic signed [W-1:0]  pk_w;
    logic signed [OW-1:0] sn;
    logic signed [OW-1:0] cs;

    scqap_qmul u_mul_sn (
        .aclk (aclk), .en (en), .a (m1_reg), .b (r_reg), .c ('0), .y (pn_w)
    );
    scqap_qmul u_mul_cn (
        .aclk (aclk), .en (en), .a (ss_reg), .b (sm_reg), .c ('0), .y (pk_w)
    );

    assign sn = OW'(pn_w) <<< 2;
    assign cs = OW'(scqap_pkg::ONE_Q) + (OW'(pk_w) <<< 3);

    // Result register: the last pipeline stage, holding while the transaction
    // waits to be taken.
    always_ff @(posedge aclk) begin
        if (en) begin
            m_sine   <= to_result(sn);
            m_cosine <= to_result(cs);
        end
    end

endmodule
